[rtl/core/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 stream converter.
// Used by the decode logic, the result register and the top level.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

	// Configuration register indexes.
	localparam logic [7:0] CFG_BIG_ENDIAN = 8'd0;
	localparam logic [7:0] CFG_COUNT_ONLY = 8'd1;

	localparam logic [15:0] UNIT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEQ_NONE  = 2'd0,
		SEQ_TWO   = 2'd1,
		SEQ_THREE = 2'd2,
		SEQ_FOUR  = 2'd3
	} seq_kind_t;

	typedef struct packed {
		logic [1:0]  pending;
		seq_kind_t   kind;
		logic [7:0]  lead;
		logic [7:0]  middle;
		logic        halted;
		logic [15:0] unit_cnt;
	} stream_state_t;

	typedef struct packed {
		logic [7:0]  out_first;
		logic [7:0]  out_second;
		logic        unit_valid;
		logic        end_of_stream;
		status_t     status;
		logic [15:0] unit_total;
	} result_t;

	localparam stream_state_t STATE_CLEAR = '{
		pending:  2'd0,
		kind:     SEQ_NONE,
		lead:     8'd0,
		middle:   8'd0,
		halted:   1'b0,
		unit_cnt: 16'd0
	};

endpackage

[rtl/core/u8u16_decode.sv]
// Combinational decode step: one UTF-8 byte against the current stream state.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_decode
	import u8u16_pkg::*;
(
	input  stream_state_t st,
	input  logic [7:0]    in_byte,
	input  logic          last_byte,
	input  logic          big_endian,
	input  logic          count_only,
	output stream_state_t st_next,
	output result_t       res,
	output logic          res_valid
);

	stream_state_t upd;
	logic          have;
	logic [15:0]   unit;
	logic          emit;

	always_comb begin
		upd  = st;
		have = 1'b0;
		unit = 16'd0;
		if (!st.halted) begin
			if (st.pending != 2'd0) begin
				if (st.kind == SEQ_THREE && st.pending == 2'd2) begin
					upd.middle = in_byte;
				end
				upd.pending = st.pending - 2'd1;
				if (st.pending == 2'd1) begin
					unique case (st.kind)
						SEQ_TWO:   unit = {5'd0, st.lead[4:0], in_byte[5:0]};
						SEQ_THREE: unit = {st.lead[3:0], upd.middle[5:0], in_byte[5:0]};
						default:   unit = UNIT_MAX;
					endcase
					have     = 1'b1;
					upd.kind = SEQ_NONE;
				end
			end else if (in_byte[7:3] == 5'b11110) begin
				upd.kind    = SEQ_FOUR;
				upd.pending = 2'd3;
				upd.lead    = in_byte;
			end else if (in_byte[7:4] == 4'b1110) begin
				upd.kind    = SEQ_THREE;
				upd.pending = 2'd2;
				upd.lead    = in_byte;
			end else if (in_byte[7:5] == 3'b110) begin
				upd.kind    = SEQ_TWO;
				upd.pending = 2'd1;
				upd.lead    = in_byte;
			end else if (!in_byte[7]) begin
				unit = {8'd0, in_byte};
				have = 1'b1;
			end else begin
				upd.halted = 1'b1;
			end
		end
		if (have && st.unit_cnt != UNIT_MAX) begin
			upd.unit_cnt = st.unit_cnt + 16'd1;
		end

		emit      = have && !count_only;
		res_valid = last_byte || emit;

		res.status = ST_OK;
		if (last_byte) begin
			if (upd.halted) begin
				res.status = ST_INVALID;
			end else if (upd.pending != 2'd0) begin
				res.status = ST_TRUNC;
			end
		end
		if (emit) begin
			res.out_first  = big_endian ? unit[15:8] : unit[7:0];
			res.out_second = big_endian ? unit[7:0] : unit[15:8];
		end else begin
			res.out_first  = 8'd0;
			res.out_second = 8'd0;
		end
		res.unit_valid    = emit;
		res.end_of_stream = last_byte;
		res.unit_total    = upd.unit_cnt;

		st_next = last_byte ? STATE_CLEAR : upd;
	end

endmodule

[rtl/core/u8u16_outreg.sv]
// Result register holding one finished result beat until the sink takes it.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_outreg
	import u8u16_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_res,
	output logic    free,
	input  logic    sink_ready,
	output logic    res_valid,
	output result_t res
);

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || sink_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (sink_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

endmodule

[rtl/core/utf8_to_utf16_decoder.sv]
// A byte accepted into the input register is decoded combinationally, and its
// result beat (if any) is loaded into the result register when the byte retires.
// Throughput: one byte per cycle while the result register can take each result.
// Reset clears the stream state and both valid flags; big_endian resets to 1
// and count_only to 0. Top level of the UTF-8 to UTF-16 stream converter.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// UTF-8 input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // last_byte
	// UTF-16 result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_first, [15:8] out_second, [31:16] unit_total
	output logic [2:0]  m_axis_tuser,   // [0] unit_valid, [2:1] status
	output logic        m_axis_tlast,   // end_of_stream
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// Input register: one beat waiting for decode.
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	// Configuration and stream state.
	logic          big_endian_q;
	logic          count_only_q;
	stream_state_t st_q;

	stream_state_t st_next;
	result_t       dec_res;
	logic          dec_res_valid;
	logic          out_free;
	logic          retire;
	result_t       out_res;

	// The byte in the input register retires when its result (if any) can be
	// loaded into the result register. A byte that makes no result always retires.
	assign retire        = valid_s1 && (out_free || !dec_res_valid);
	assign s_axis_tready = !valid_s1 || retire;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Writes are only to be made while the stream is idle; the block itself does not enforce this and has no interlock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			count_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_BIG_ENDIAN) begin
				big_endian_q <= cfg_data[0];
			end
			if (cfg_index == CFG_COUNT_ONLY) begin
				count_only_q <= cfg_data[0];
			end
		end
	end

	// Stream state advances once per retired byte; the final byte clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (retire) begin
			st_q <= st_next;
		end
	end

	u8u16_decode u_decode (
		.st         (st_q),
		.in_byte    (byte_s1),
		.last_byte  (last_s1),
		.big_endian (big_endian_q),
		.count_only (count_only_q),
		.st_next    (st_next),
		.res        (dec_res),
		.res_valid  (dec_res_valid)
	);

	u8u16_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (retire && dec_res_valid),
		.load_res   (dec_res),
		.free       (out_free),
		.sink_ready (m_axis_tready),
		.res_valid  (m_axis_tvalid),
		.res        (out_res)
	);

	assign m_axis_tdata = {out_res.unit_total, out_res.out_second, out_res.out_first};
	assign m_axis_tuser = {out_res.status, out_res.unit_valid};
	assign m_axis_tlast = out_res.end_of_stream;

	// A result beat without a code unit is only the end-of-stream report.
	a_unitless_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("result beat without unit is not end of stream");

	// A non-ok status is only reported on the final beat.
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> m_axis_tlast)
		else $error("non-ok status on a beat that is not end of stream");

	// Pending count and sequence kind agree on whether a sequence is open.
	a_pending_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.pending == 2'd0) == (st_q.kind == SEQ_NONE))
		else $error("pending count and sequence kind disagree");

	// Once halted, no sequence can be open.
	a_halted_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |-> st_q.pending == 2'd0)
		else $error("halted with a sequence open");

	// Retiring the final byte returns the stream state to its cleared value.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		retire && last_s1 |=> st_q == STATE_CLEAR)
		else $error("stream state not cleared after final byte");

endmodule
